FILE: sv/pidc_pkg.sv
// Package for the PID duty controller: payload structs, register indexes,
// microcode control word and program ROM, and saturation helpers.
// No dependencies.
package pidc_pkg;

    localparam int STEP_W   = 4;
    localparam int PROG_LEN = 10;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;

    typedef struct packed {
        logic [30:0]        target_magnitude;
        logic               target_positive;
        logic signed [31:0] measured;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] command;
        logic [16:0]        duty;
        logic               forward;
    } out_item_t;

    typedef enum logic [IDX_W-1:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_INV_DT    = 3'd3,
        REG_INTEG_MIN = 3'd4,
        REG_INTEG_MAX = 3'd5,
        REG_MAX_DUTY  = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_ERR,
        ALU_DIFF,
        ALU_INTEG_ADD,
        ALU_INTEG_CLAMP,
        ALU_CMD_SAT,
        ALU_DUTY
    } alu_op_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP_ERR,
        MUL_DIFF_INV,
        MUL_KI_INT,
        MUL_KD_DER
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD
    } acc_op_t;

    typedef enum logic {
        FLOW_NEXT,
        FLOW_EMIT
    } flow_op_t;

    typedef struct packed {
        alu_op_t  alu;
        mul_op_t  mul;
        acc_op_t  acc;
        logic     deriv_ld;
        flow_op_t flow;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{alu: ALU_NOP, mul: MUL_NONE, acc: ACC_HOLD, deriv_ld: 1'b0,
               flow: FLOW_NEXT};
        unique case (step)
            4'd0: begin cw.alu = ALU_ERR;       cw.acc = ACC_CLEAR; end
            4'd1: begin cw.alu = ALU_DIFF;      cw.mul = MUL_KP_ERR; end
            4'd2:
            begin
                cw.alu = ALU_INTEG_ADD;
                cw.mul = MUL_DIFF_INV;
                cw.acc = ACC_ADD;
            end
            4'd3: begin cw.alu = ALU_INTEG_CLAMP; cw.deriv_ld = 1'b1; end
            4'd4: begin cw.mul = MUL_KI_INT; end
            4'd5: begin cw.mul = MUL_KD_DER;    cw.acc = ACC_ADD; end
            4'd6: begin cw.acc = ACC_ADD; end
            4'd7: begin cw.alu = ALU_CMD_SAT; end
            4'd8: begin cw.alu = ALU_DUTY; end
            4'd9: begin cw.flow = FLOW_EMIT; end
            default: cw.flow = FLOW_EMIT;
        endcase
        return cw;
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic signed [47:0] s;
        logic signed [31:0] r;
        s = 48'(p >>> 16);
        if (s > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (s < -48'sh0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

FILE: sv/pid_duty_controller_top.sv
// PID duty controller top level: microcoded sequencer over one shared
// 32x32 multiplier, one 34-bit adder, accumulator and state registers.
// An input transfers only while idle, then the sequencer runs the 10 program steps
// and raises out_valid; no new item is taken until the result is emitted, and
// a waiting result holds the last step until it is taken.
// rst_n clears control, state and config registers to their reset values.
module pid_duty_controller_top
    import pidc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data
);

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0]        inv_dt_reg;
    logic signed [31:0] integ_min_reg, integ_max_reg;
    logic [16:0]        max_duty_reg;

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  pc_reg, pc_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg;

    in_item_t           item_reg;
    logic signed [31:0] err_reg, diff_reg, deriv_reg, cmd_reg;
    logic signed [31:0] integ_reg, last_reg;
    logic [16:0]        duty_reg;
    logic signed [33:0] acc_reg;
    logic signed [63:0] prod_reg;

    ctrl_word_t         cw;
    logic               in_xfer;
    logic               emit;
    logic signed [31:0] mul_a, mul_b;
    logic signed [33:0] add_a, add_b, add_sum;
    logic signed [31:0] add_sat, qprod;
    logic [16:0]        duty_new;

    assign cw       = prog_rom(pc_reg);
    assign in_stall = busy_reg;
    assign in_xfer  = in_valid && !busy_reg;
    assign emit     = busy_reg && (cw.flow == FLOW_EMIT) && !(out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            inv_dt_reg    <= 31'd65536;
            integ_min_reg <= -32'sd6553600;
            integ_max_reg <= 32'sd6553600;
            max_duty_reg  <= 17'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP:        kp_reg        <= cfg_data;
                REG_KI:        ki_reg        <= cfg_data;
                REG_KD:        kd_reg        <= cfg_data;
                REG_INV_DT:    inv_dt_reg    <= cfg_data[30:0];
                REG_INTEG_MIN: integ_min_reg <= cfg_data;
                REG_INTEG_MAX: integ_max_reg <= cfg_data;
                REG_MAX_DUTY:  max_duty_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (in_xfer)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (busy_reg)
        begin
            unique case (cw.flow)
                FLOW_NEXT: pc_next = pc_reg + 1'b1;
                FLOW_EMIT:
                begin
                    if (emit)
                    begin
                        busy_next      = 1'b0;
                        pc_next        = '0;
                        out_valid_next = 1'b1;
                    end
                end
                default: pc_next = pc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = kp_reg;
        mul_b = err_reg;
        unique case (cw.mul)
            MUL_KP_ERR:   begin mul_a = kp_reg;   mul_b = err_reg; end
            MUL_DIFF_INV: begin mul_a = diff_reg; mul_b = {1'b0, inv_dt_reg}; end
            MUL_KI_INT:   begin mul_a = ki_reg;   mul_b = integ_reg; end
            MUL_KD_DER:   begin mul_a = kd_reg;   mul_b = deriv_reg; end
            default:      begin mul_a = kp_reg;   mul_b = err_reg; end
        endcase
    end

    assign qprod = qsat(prod_reg);

    // Adder operand select
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (cw.alu)
            ALU_ERR:
            begin
                add_a = {3'b000, item_reg.target_magnitude};
                add_b = -34'(item_reg.measured);
            end
            ALU_DIFF:
            begin
                add_a = 34'(item_reg.measured);
                add_b = -34'(last_reg);
            end
            ALU_INTEG_ADD:
            begin
                add_a = 34'(integ_reg);
                add_b = 34'(err_reg);
            end
            ALU_DUTY:
            begin
                add_a = {17'b0, duty_reg};
                add_b = 34'(cmd_reg);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;
    assign add_sat = sat34(add_sum);

    always_comb
    begin
        if (add_sum > $signed({17'b0, max_duty_reg}))
            duty_new = max_duty_reg;
        else if (add_sum < 34'sd0)
            duty_new = '0;
        else
            duty_new = add_sum[16:0];
    end

    // Loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            last_reg  <= '0;
            duty_reg  <= '0;
        end
        else if (busy_reg)
        begin
            priority case (cw.alu)
                ALU_INTEG_ADD: integ_reg <= add_sat;
                ALU_INTEG_CLAMP:
                begin
                    if (integ_reg > integ_max_reg)
                        integ_reg <= integ_max_reg;
                    else if (integ_reg < integ_min_reg)
                        integ_reg <= integ_min_reg;
                end
                ALU_CMD_SAT: last_reg <= item_reg.measured;
                ALU_DUTY:    duty_reg <= duty_new;
                default: ;
            endcase
        end
    end

    // Datapath working registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= in_data;
        if (busy_reg)
        begin
            if (cw.alu == ALU_ERR)
                err_reg <= add_sat;
            if (cw.alu == ALU_DIFF)
                diff_reg <= add_sat;
            if (cw.alu == ALU_CMD_SAT)
                cmd_reg <= sat34(acc_reg);
            if (cw.deriv_ld)
                deriv_reg <= qprod;
            if (cw.mul != MUL_NONE)
                prod_reg <= mul_a * mul_b;
            unique case (cw.acc)
                ACC_CLEAR: acc_reg <= '0;
                ACC_ADD:   acc_reg <= acc_reg + 34'(qprod);
                default: ;
            endcase
        end
        if (emit)
        begin
            out_reg.command <= cmd_reg;
            out_reg.duty    <= duty_reg;
            out_reg.forward <= !item_reg.target_positive;
        end
    end

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> busy_reg && (pc_reg == '0))
        else $error("transfer did not start the program");

    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_valid_reg)
        else $error("program ended without a result");

    a_pc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pc_reg == '0))
        else $error("step counter moved while idle");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < STEP_W'(PROG_LEN))
        else $error("step counter past program end");
`endif

endmodule

FILE: sim/pid_duty_controller_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pid_duty_controller_top: directed and random control ticks
// checked against an in-bench Q16.16 model of the PID loop and duty clamp.
// Depends on pidc_pkg (sv/pidc_pkg.sv) and the top level RTL.
module pid_duty_controller_top_tb;
    import pidc_pkg::*;

    localparam int                ONE         = 65536;
    localparam int                LATENCY     = 11;
    localparam int                CYCLE_LIMIT = 500000;
    localparam logic [IDX_W-1:0]  REG_UNUSED  = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;

    pid_duty_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // controller model: registers and loop state
    longint kp_g, ki_g, kd_g, inv_dt_g, integ_lo, integ_hi, duty_cap;
    longint integ_acc, prev_meas, duty_acc;

    out_item_t   expected_outputs[$];
    out_item_t   want;
    int unsigned ticks_sent;
    int unsigned outputs_seen;
    int unsigned reg_writes;
    int unsigned fault_count;
    int unsigned cycle_count;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          calm;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void reset_model();
        kp_g      = 0;
        ki_g      = 0;
        kd_g      = 0;
        inv_dt_g  = ONE;
        integ_lo  = -100 * ONE;
        integ_hi  = 100 * ONE;
        duty_cap  = ONE;
        integ_acc = 0;
        prev_meas = 0;
        duty_acc  = 0;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    function automatic longint fixmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip32(p >>> 16);
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
        case (idx)
            REG_KP:        kp_g     = longint'($signed(v));
            REG_KI:        ki_g     = longint'($signed(v));
            REG_KD:        kd_g     = longint'($signed(v));
            REG_INV_DT:    inv_dt_g = longint'(v[30:0]);
            REG_INTEG_MIN: integ_lo = longint'($signed(v));
            REG_INTEG_MAX: integ_hi = longint'($signed(v));
            REG_MAX_DUTY:  duty_cap = longint'(v[16:0]);
            default: ;
        endcase
    endfunction

    function automatic out_item_t advance_controller(input in_item_t t);
        longint    tgt, meas, err, rate, cmd, nd;
        out_item_t r;
        tgt  = longint'(t.target_magnitude);
        meas = longint'($signed(t.measured));
        err  = clip32(tgt - meas);
        rate = fixmul(clip32(meas - prev_meas), inv_dt_g);
        integ_acc = clip32(integ_acc + err);
        if (integ_acc > integ_hi)
            integ_acc = integ_hi;
        else if (integ_acc < integ_lo)
            integ_acc = integ_lo;
        cmd = clip32(fixmul(kp_g, err) + fixmul(ki_g, integ_acc) + fixmul(kd_g, rate));
        prev_meas = meas;
        nd = duty_acc + cmd;
        if (nd > duty_cap)
            nd = duty_cap;
        else if (nd < 0)
            nd = 0;
        duty_acc  = nd;
        r.command = cmd[31:0];
        r.duty    = nd[16:0];
        r.forward = !t.target_positive;
        return r;
    endfunction

    function automatic in_item_t tick(input logic [30:0] mag, input bit pos,
                                      input logic [31:0] meas);
        in_item_t t;
        t.target_magnitude = mag;
        t.target_positive  = pos;
        t.measured         = meas;
        return t;
    endfunction

    function automatic logic [31:0] pick_word(input int unsigned style);
        if (style == 0)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic in_item_t make_tick(input bit wild);
        in_item_t t;
        int       m;
        if (wild)
        begin
            t.target_magnitude = 31'($urandom);
            t.target_positive  = 1'($urandom);
            t.measured         = ($urandom_range(0, 3) == 0) ? pick_word(1) : $urandom;
        end
        else
        begin
            m = $urandom_range(0, 20 * ONE);
            t.target_magnitude = 31'(m);
            t.target_positive  = 1'($urandom);
            t.measured         = m + int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        end
        return t;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, v);
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic send_tick(input in_item_t t);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_outputs.push_back(advance_controller(t));
        ticks_sent++;
    endtask

    // drop valid and wait for every pending output
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(tick(31'h7FFF_FFFF, 1'b1, 32'h8000_0000));
        send_tick(tick(31'h0, 1'b0, 32'h7FFF_FFFF));
        send_tick(tick(31'h0, 1'b1, 32'h0));
        send_tick(tick(31'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF));
        settle();
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_KP, 32'h7FFF_FFFF);
        write_reg(REG_KI, 32'h8000_0000);
        write_reg(REG_KD, 32'h7FFF_FFFF);
        write_reg(REG_INV_DT, 32'h7FFF_FFFF);
        write_reg(REG_INTEG_MIN, 32'h8000_0000);
        write_reg(REG_INTEG_MAX, 32'h7FFF_FFFF);
        write_reg(REG_MAX_DUTY, 32'h0001_FFFF);
        send_tick(tick(31'h7FFF_FFFF, 1'b1, 32'h8000_0000));
        send_tick(tick(31'h0, 1'b0, 32'h7FFF_FFFF));
        send_tick(tick(31'd12345, 1'b1, -32'sd5));
        settle();
    endtask

    task automatic test_integrator_and_duty();
        write_reg(REG_KP, ONE);
        write_reg(REG_KI, ONE / 2);
        write_reg(REG_KD, ONE / 4);
        write_reg(REG_INV_DT, ONE);
        write_reg(REG_INTEG_MIN, -10 * ONE);
        write_reg(REG_INTEG_MAX, 10 * ONE);
        write_reg(REG_MAX_DUTY, ONE);
        send_tick(tick(31'(8 * ONE), 1'b1, 32'h0));
        send_tick(tick(31'(8 * ONE), 1'b1, 32'h0));
        send_tick(tick(31'h0, 1'b0, 30 * ONE));
        settle();
        // half gain on a one-LSB error rounds down
        write_reg(REG_KP, ONE / 2);
        send_tick(tick(31'h0, 1'b1, 32'h1));
        send_tick(tick(31'd3, 1'b0, 32'h0));
        settle();
    endtask

    task automatic test_crossed_limits();
        write_reg(REG_INTEG_MIN, 5 * ONE);
        write_reg(REG_INTEG_MAX, -5 * ONE);
        send_tick(tick(31'(20 * ONE), 1'b1, 32'h0));
        send_tick(tick(31'h0, 1'b0, 2 * ONE));
        send_tick(tick(31'h0, 1'b1, 32'h0));
        settle();
    endtask

    task automatic test_duty_limits();
        write_reg(REG_MAX_DUTY, 32'h0);
        send_tick(tick(31'(5 * ONE), 1'b1, 32'h0));
        settle();
        write_reg(REG_MAX_DUTY, 32'h0001_FFFF);
        send_tick(tick(31'(5 * ONE), 1'b0, 32'h0));
        send_tick(tick(31'(5 * ONE), 1'b1, 32'h0));
        settle();
    endtask

    task automatic test_ignored_writes();
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        write_reg(REG_INV_DT, 32'h8003_0000);
        write_reg(REG_MAX_DUTY, 32'hFFFE_8000);
        write_reg(REG_KD, ONE);
        send_tick(tick(31'(ONE), 1'b1, -4 * ONE));
        send_tick(tick(31'(ONE), 1'b0, 4 * ONE));
        settle();
    endtask

    task automatic shuffle_config(input bit tame);
        logic [31:0] lo, hi;
        if (tame)
        begin
            write_reg(REG_KP, $urandom_range(0, ONE / 2) - ONE / 4);
            write_reg(REG_KI, $urandom_range(0, ONE / 32) - ONE / 64);
            write_reg(REG_KD, $urandom_range(0, ONE / 8) - ONE / 16);
            write_reg(REG_INV_DT, $urandom_range(ONE / 4, 4 * ONE));
            lo = -$urandom_range(0, 200 * ONE);
            hi = $urandom_range(0, 200 * ONE);
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_INTEG_MIN, hi);
                write_reg(REG_INTEG_MAX, lo);
            end
            else
            begin
                write_reg(REG_INTEG_MIN, lo);
                write_reg(REG_INTEG_MAX, hi);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_MAX_DUTY, $urandom_range(0, 131071));
            else
                write_reg(REG_MAX_DUTY, $urandom_range(ONE / 2, ONE));
        end
        else
        begin
            write_reg(REG_KP, pick_word($urandom_range(0, 1)));
            write_reg(REG_KI, pick_word($urandom_range(0, 1)));
            write_reg(REG_KD, pick_word($urandom_range(0, 1)));
            write_reg(REG_INV_DT, pick_word($urandom_range(0, 1)));
            write_reg(REG_INTEG_MIN, pick_word($urandom_range(0, 1)));
            write_reg(REG_INTEG_MAX, pick_word($urandom_range(0, 1)));
            write_reg(REG_MAX_DUTY, $urandom);
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 11; p++)
        begin
            gap_pct   = (p % 4 == 3) ? 0 : $urandom_range(5, 40);
            stall_pct = (p % 4 == 2) ? 0 : $urandom_range(2, 15);
            shuffle_config(p % 3 != 2);
            repeat (150)
            begin
                send_tick(make_tick($urandom_range(0, 9) == 0));
                if ($urandom_range(0, 199) == 0)
                    settle();
            end
            settle();
        end
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        shuffle_config(1'b1);
        repeat (200) send_tick(make_tick($urandom_range(0, 9) == 0));
        settle();
    endtask

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            outputs_seen++;
            if (expected_outputs.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected transfer: cmd %h duty %h fwd %b",
                             out_data.command, out_data.duty, out_data.forward);
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (out_data.command !== want.command || out_data.duty !== want.duty ||
                    out_data.forward !== want.forward)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch on output %0d: want cmd %h duty %h fwd %b, got cmd %h duty %h fwd %b",
                                 outputs_seen, want.command, want.duty, want.forward,
                                 out_data.command, out_data.duty, out_data.forward);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("pid_duty_controller_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        rst_n       <= 1'b0;
        cycle_count = 0;
        ticks_sent  = 0;
        outputs_seen = 0;
        reg_writes  = 0;
        fault_count = 0;
        gap_pct     = 20;
        stall_pct   = 5;
        calm        = 1'b0;
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_gain_extremes();
        test_integrator_and_duty();
        test_crossed_limits();
        test_duty_limits();
        test_ignored_writes();
        test_random_phases();
        test_steady_stream();

        repeat (2 * LATENCY) @(posedge clk);
        fault_count += expected_outputs.size();
        $display("run covered %0d control ticks and %0d checked outputs over %0d register writes",
                 ticks_sent, outputs_seen, reg_writes);
        $display("gain, clamp and duty-limit corners plus random phases; %0d failures",
                 fault_count);
        if (fault_count == 0)
            $display("pid_duty_controller_top_tb: clean");
        else
            $display("pid_duty_controller_top_tb: errors");
        $finish;
    end

endmodule
